// ===== src/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and the hex digit function for the chunked body decoder.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int unsigned BUDGET_BITS  = 33;
    localparam logic [31:0] RESET_BUDGET = 32'd1048576;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_EXT   = 3'd1,
        PH_DATA  = 3'd2,
        PH_TR_CR = 3'd3,
        PH_TR_LF = 3'd4,
        PH_HALT  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_DONE  = 2'd1,
        K_BAD   = 2'd2,
        K_LARGE = 2'd3
    } kind_t;

    // one result request from the core to the output stage
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
    } result_t;

    // bit 4 set when the character is a hex digit, low nibble its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== src/cbd_core.sv =====
// ----------------------------------------------------------------------------
// cbd_core
// Decoder state registers and the combinational next-state and result logic.
// ----------------------------------------------------------------------------
module cbd_core #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  logic [7:0]                   in_byte,
    input  logic                         cfg_wr_en,
    input  logic [31:0]                  cfg_wr_data,
    output cbd_pkg::result_t             result
);
    import cbd_pkg::*;

    localparam int unsigned CMP_BITS = (COUNT_BITS > BUDGET_BITS) ? COUNT_BITS : BUDGET_BITS;

    phase_t                  phase_reg,  phase_next;
    logic [COUNT_BITS-1:0]   accum_reg,  accum_next;
    logic                    saw_reg,    saw_next;
    logic                    over_reg,   over_next;
    logic [COUNT_BITS-1:0]   chunk_reg,  chunk_next;
    logic [BUDGET_BITS-1:0]  budget_reg, budget_next;

    logic                    do_size;
    logic                    in_ext;
    logic [4:0]              hex;
    logic [CMP_BITS-1:0]     size_ext;
    logic [CMP_BITS-1:0]     budget_ext;
    logic [COUNT_BITS-1:0]   chunk_dec;

    assign hex        = hex_value(in_byte);
    assign size_ext   = CMP_BITS'(accum_reg);
    assign budget_ext = CMP_BITS'(budget_reg);
    assign chunk_dec  = (chunk_reg != '0) ? chunk_reg - COUNT_BITS'(1) : chunk_reg;

    always_comb begin
        phase_next          = phase_reg;
        accum_next          = accum_reg;
        saw_next            = saw_reg;
        over_next           = over_reg;
        chunk_next          = chunk_reg;
        budget_next         = budget_reg;
        result.valid        = 1'b0;
        result.kind         = K_DATA;
        result.payload_byte = 8'd0;
        do_size             = 1'b0;
        in_ext              = 1'b0;

        if (in_fire) begin
            case (phase_reg)
                PH_SIZE, PH_EXT: begin
                    do_size = 1'b1;
                    in_ext  = (phase_reg == PH_EXT);
                end
                PH_DATA: begin
                    chunk_next          = chunk_dec;
                    if (chunk_dec == '0) begin
                        phase_next = PH_TR_CR;
                    end
                    result.valid        = 1'b1;
                    result.payload_byte = in_byte;
                end
                PH_TR_CR: begin
                    if (in_byte == CH_CR) begin
                        phase_next = PH_TR_LF;
                    end else begin
                        phase_next = PH_SIZE;
                        do_size    = (in_byte != CH_LF);
                    end
                end
                PH_TR_LF: begin
                    phase_next = PH_SIZE;
                    do_size    = (in_byte != CH_LF);
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase

            if (do_size) begin
                if (in_byte == CH_LF) begin
                    // end of size line
                    accum_next = '0;
                    saw_next   = 1'b0;
                    over_next  = 1'b0;
                    if (!saw_reg || over_reg) begin
                        result.valid = 1'b1;
                        result.kind  = K_BAD;
                        phase_next   = PH_HALT;
                    end else if (size_ext >= budget_ext) begin
                        result.valid = 1'b1;
                        result.kind  = K_LARGE;
                        phase_next   = PH_HALT;
                    end else begin
                        budget_next = BUDGET_BITS'(budget_ext - size_ext);
                        if (accum_reg == '0) begin
                            result.valid = 1'b1;
                            result.kind  = K_DONE;
                            phase_next   = PH_HALT;
                        end else begin
                            chunk_next = accum_reg;
                            phase_next = PH_DATA;
                        end
                    end
                end else if (in_byte != CH_CR && !in_ext) begin
                    if (!hex[4]) begin
                        phase_next = PH_EXT;
                    end else begin
                        if (accum_reg[COUNT_BITS-1:COUNT_BITS-4] != 4'd0) begin
                            over_next = 1'b1;
                        end
                        accum_next = {accum_reg[COUNT_BITS-5:0], hex[3:0]};
                        saw_next   = 1'b1;
                    end
                end
            end
        end

        if (cfg_wr_en) begin
            budget_next = {1'b0, cfg_wr_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SIZE;
            accum_reg  <= '0;
            saw_reg    <= 1'b0;
            over_reg   <= 1'b0;
            chunk_reg  <= '0;
            budget_reg <= {1'b0, RESET_BUDGET};
        end else begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            saw_reg    <= saw_next;
            over_reg   <= over_next;
            chunk_reg  <= chunk_next;
            budget_reg <= budget_next;
        end
    end

endmodule

// ===== src/cbd_out_stage.sv =====
// ----------------------------------------------------------------------------
// cbd_out_stage
// Output register holding one result until the receiver takes it.
// ----------------------------------------------------------------------------
module cbd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  cbd_pkg::result_t result,
    output logic             take_ok,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic [1:0]       m_tuser
);
    import cbd_pkg::*;

    logic       valid_reg,  valid_next;
    logic [7:0] data_reg,   data_next;
    logic [1:0] user_reg,   user_next;

    // a new item may enter when the register is empty or drains this cycle
    assign take_ok = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        if (result.valid) begin
            valid_next = 1'b1;
            data_next  = result.payload_byte;
            user_next  = result.kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== src/chunked_body_decoder_top.sv =====
// ----------------------------------------------------------------------------
// chunked_body_decoder_top
// HTTP chunked body decoder, one raw byte in, at most one result out.
// ----------------------------------------------------------------------------
// Raw body bytes enter on the s_ stream, one byte per beat in s_tdata.
// Results leave on the m_ stream: m_tuser carries the kind (payload byte,
// body complete, bad request, entity too large) and m_tdata the payload
// byte, zero for the other kinds. Extensions, the CRLF after each chunk and
// size lines produce no result, except a terminal report at a size line's LF.
// Throughput is one byte per cycle while no held result waits. Each byte is
// decoded in the cycle it is accepted and its result sits in the output
// register in the cycle after; the state update per byte (hex shift, budget
// compare and subtract, chunk count decrement) is combinational in the core.
// cfg_wr_en/cfg_wr_data write the body size budget and reload the remaining
// budget; write only while no byte is in flight.
// Reset restores the budget to 1048576 and starts at a size line. After a
// terminal report all bytes are accepted and dropped until reset.
// When the receiver stalls, one result is held and s_tready drops only while
// that held result is not being taken.
// ----------------------------------------------------------------------------
module chunked_body_decoder_top #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] payload_byte
    output logic [1:0]  m_tuser,     // [1:0] kind
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import cbd_pkg::*;

    result_t result;
    logic    take_ok;
    logic    in_fire;

    assign s_tready = take_ok;
    assign in_fire  = s_tvalid && take_ok;

    cbd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    cbd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .take_ok  (take_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
